// ===== rtl/core/lscf_pkg.sv =====
package lscf_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int COORD_BITS_DEF = 11;
  localparam int FRAC_BITS_DEF  = 16;

  // exact solve runs modulo 2^BIG_W
  localparam int BIG_W   = 192;
  localparam int ITER_W  = $clog2(BIG_W);
  localparam int OUT_W   = 48;
  localparam int UOP_W   = 4;
  localparam int UOP_LAST = 8;

  typedef enum logic [3:0] {
    SRC_M00, SRC_M01, SRC_M02,
    SRC_M10, SRC_M11, SRC_M12,
    SRC_M20, SRC_M21, SRC_M22,
    SRC_T0,  SRC_T1,  SRC_T2
  } src_t;

  typedef enum logic [1:0] {
    MOP_SET, MOP_SUB, MOP_ADD
  } mop_t;

  typedef enum logic [1:0] {
    DST_NONE, DST_T0, DST_T1, DST_T2
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    mop_t op;
    dst_t dst;
  } uop_t;

  // 3x3 determinant by cofactors along the first row
  function automatic uop_t uop_rom(input logic [UOP_W-1:0] idx);
    uop_t u;
    case (idx)
      4'd0:    u = '{SRC_M11, SRC_M22, MOP_SET, DST_NONE};
      4'd1:    u = '{SRC_M12, SRC_M21, MOP_SUB, DST_T0};
      4'd2:    u = '{SRC_M10, SRC_M22, MOP_SET, DST_NONE};
      4'd3:    u = '{SRC_M12, SRC_M20, MOP_SUB, DST_T1};
      4'd4:    u = '{SRC_M10, SRC_M21, MOP_SET, DST_NONE};
      4'd5:    u = '{SRC_M11, SRC_M20, MOP_SUB, DST_T2};
      4'd6:    u = '{SRC_M00, SRC_T0,  MOP_SET, DST_NONE};
      4'd7:    u = '{SRC_M01, SRC_T1,  MOP_SUB, DST_NONE};
      4'd8:    u = '{SRC_M02, SRC_T2,  MOP_ADD, DST_NONE};
      default: u = '{SRC_M00, SRC_M00, MOP_SET, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/least_squares_circle_fit_core.sv =====
// Kasa circle fit. For each point the accept cycle registers the squares and reads the sum
// memory, the next cycle adds the products and writes the sums back; a further point is
// taken only after that write-back. A point with last_point set then starts the exact
// solve of the normal equations, four 3x3 determinants of 9 products each on one
// shift-add multiplier and three restoring divisions, or only the first determinant when
// that determinant is zero. No point is taken during the solve. The result sits in an
// output register, so a new set may start while it waits to be taken.
module least_squares_circle_fit_core #(
  parameter int MAX_POINTS = lscf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = lscf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = lscf_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_point_x,
  input  logic signed [COORD_BITS-1:0]       in_point_y,
  input  logic                               in_last_point,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lscf_pkg::OUT_W-1:0]  out_coef_a,
  output logic signed [lscf_pkg::OUT_W-1:0]  out_coef_b,
  output logic signed [lscf_pkg::OUT_W-1:0]  out_coef_c,
  output logic                               out_degenerate,
  output logic                               out_saturated
);

  localparam int BW     = lscf_pkg::BIG_W;
  localparam int OW     = lscf_pkg::OUT_W;
  localparam int C      = COORD_BITS;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int XX_W   = (2*C + CNT_W - 1 > 64) ? 64 : 2*C + CNT_W - 1;
  localparam int X_W    = C + CNT_W;
  localparam int Z_W    = (2*C + CNT_W > 64) ? 64 : 2*C + CNT_W;
  localparam int XZ_W   = (3*C + CNT_W > 64) ? 64 : 3*C + CNT_W;
  localparam int MW     = 3*XX_W + 2*X_W + CNT_W + 2*XZ_W + Z_W;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ACC  = 11'b000_0000_0010,
    ST_LD   = 11'b000_0000_0100,
    ST_MUL  = 11'b000_0000_1000,
    ST_UPD  = 11'b000_0001_0000,
    ST_FIN  = 11'b000_0010_0000,
    ST_DVL  = 11'b000_0100_0000,
    ST_DIV  = 11'b000_1000_0000,
    ST_RND  = 11'b001_0000_0000,
    ST_SAT  = 11'b010_0000_0000,
    ST_EMIT = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // point stage
  logic signed [C-1:0]   px_r, py_r;
  logic signed [2*C-1:0] xx_r, yy_r, xy_r;
  logic                  last_r;
  logic signed [2*C-1:0] xx_w, yy_w, xy_w;

  // sum memory
  logic [MW-1:0] sum_mem [1];
  logic [MW-1:0] rd_word_r, rd_word, new_word, snap_r;
  logic          mem_vld_r, rd_vld_r;

  logic signed [XX_W-1:0]  rd_xx, rd_xy, rd_yy, nw_xx, nw_xy, nw_yy, sn_xx, sn_xy, sn_yy;
  logic signed [X_W-1:0]   rd_x, rd_y, nw_x, nw_y, sn_x, sn_y;
  logic [CNT_W-1:0]        rd_cnt, nw_cnt, sn_cnt;
  logic signed [XZ_W-1:0]  rd_xz, rd_yz, nw_xz, nw_yz, sn_xz, sn_yz;
  logic signed [Z_W-1:0]   rd_z, nw_z, sn_z;
  logic signed [2*C:0]     z_w;
  logic signed [3*C:0]     xz_w, yz_w;
  logic                    full;

  // solve
  logic [1:0]                    k_r;
  logic [lscf_pkg::UOP_W-1:0]    uop_r;
  logic [lscf_pkg::ITER_W-1:0]   it_r;
  logic [BW-1:0] pa_r, pb_r, pp_r, acc_r, t0_r, t1_r, t2_r, det_r, num_r;
  logic [BW-1:0] nsh_r, rem_r, quo_r, dabs_r;
  logic [BW-1:0] acc_nxt, rem_sh, rem_dbl, lim, num_abs, det_abs;
  logic          neg_r, sat_r, degen_r, rem_ge, over;
  logic [OW-1:0] coefa_r, coefb_r, coefc_r, qv, sval;
  lscf_pkg::uop_t uop;
  logic [BW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, rhs0, rhs1, rhs2;
  logic [2:0]    rep;

  // output register
  logic                 out_valid_r, out_degen_r, out_sat_r, out_load;
  logic signed [OW-1:0] out_a_r, out_b_r, out_c_r;

  assign in_stall = (state_r != ST_IDLE);

  assign xx_w = in_point_x * in_point_x;
  assign yy_w = in_point_y * in_point_y;
  assign xy_w = in_point_x * in_point_y;

  assign rd_word = rd_vld_r ? rd_word_r : '0;
  assign {rd_xx, rd_xy, rd_yy, rd_x, rd_y, rd_cnt, rd_xz, rd_yz, rd_z} = rd_word;
  assign {sn_xx, sn_xy, sn_yy, sn_x, sn_y, sn_cnt, sn_xz, sn_yz, sn_z} = snap_r;

  assign z_w  = (2*C+1)'(xx_r) + (2*C+1)'(yy_r);
  assign xz_w = px_r * z_w;
  assign yz_w = py_r * z_w;
  assign full = (rd_cnt >= CNT_W'(MAX_POINTS));

  always_comb begin
    nw_xx  = rd_xx;
    nw_xy  = rd_xy;
    nw_yy  = rd_yy;
    nw_x   = rd_x;
    nw_y   = rd_y;
    nw_cnt = rd_cnt;
    nw_xz  = rd_xz;
    nw_yz  = rd_yz;
    nw_z   = rd_z;
    if (!full) begin
      nw_xx  = rd_xx + XX_W'(xx_r);
      nw_xy  = rd_xy + XX_W'(xy_r);
      nw_yy  = rd_yy + XX_W'(yy_r);
      nw_x   = rd_x + X_W'(px_r);
      nw_y   = rd_y + X_W'(py_r);
      nw_cnt = rd_cnt + CNT_W'(1);
      nw_xz  = rd_xz + XZ_W'(xz_w);
      nw_yz  = rd_yz + XZ_W'(yz_w);
      nw_z   = rd_z + Z_W'(z_w);
    end
    new_word = {nw_xx, nw_xy, nw_yy, nw_x, nw_y, nw_cnt, nw_xz, nw_yz, nw_z};
  end

  // memory: written in the accumulate cycle, read every cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_ACC) begin
      sum_mem[0] <= last_r ? '0 : new_word;
    end
    rd_word_r <= sum_mem[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (state_r == ST_ACC) begin
        mem_vld_r <= 1'b1;
      end
      rd_vld_r <= mem_vld_r;
    end
  end

  // matrix entries; column k_r-1 takes the right-hand side
  assign m00  = BW'(sn_xx);
  assign m01  = BW'(sn_xy);
  assign m02  = BW'(sn_x);
  assign m10  = BW'(sn_xy);
  assign m11  = BW'(sn_yy);
  assign m12  = BW'(sn_y);
  assign m20  = BW'(sn_x);
  assign m21  = BW'(sn_y);
  assign m22  = BW'(sn_cnt);
  assign rhs0 = -BW'(sn_xz);
  assign rhs1 = -BW'(sn_yz);
  assign rhs2 = -BW'(sn_z);
  assign rep  = {k_r == 2'd3, k_r == 2'd2, k_r == 2'd1};

  function automatic logic [BW-1:0] src_val(input lscf_pkg::src_t sel);
    logic [BW-1:0] v;
    case (sel)
      lscf_pkg::SRC_M00: v = rep[0] ? rhs0 : m00;
      lscf_pkg::SRC_M01: v = rep[1] ? rhs0 : m01;
      lscf_pkg::SRC_M02: v = rep[2] ? rhs0 : m02;
      lscf_pkg::SRC_M10: v = rep[0] ? rhs1 : m10;
      lscf_pkg::SRC_M11: v = rep[1] ? rhs1 : m11;
      lscf_pkg::SRC_M12: v = rep[2] ? rhs1 : m12;
      lscf_pkg::SRC_M20: v = rep[0] ? rhs2 : m20;
      lscf_pkg::SRC_M21: v = rep[1] ? rhs2 : m21;
      lscf_pkg::SRC_M22: v = rep[2] ? rhs2 : m22;
      lscf_pkg::SRC_T0:  v = t0_r;
      lscf_pkg::SRC_T1:  v = t1_r;
      lscf_pkg::SRC_T2:  v = t2_r;
      default:           v = '0;
    endcase
    return v;
  endfunction

  assign uop = lscf_pkg::uop_rom(uop_r);

  always_comb begin
    case (uop.op)
      lscf_pkg::MOP_SET: acc_nxt = pp_r;
      lscf_pkg::MOP_SUB: acc_nxt = acc_r - pp_r;
      lscf_pkg::MOP_ADD: acc_nxt = acc_r + pp_r;
      default:           acc_nxt = pp_r;
    endcase
  end

  assign num_abs = num_r[BW-1] ? -num_r : num_r;
  assign det_abs = det_r[BW-1] ? -det_r : det_r;
  assign rem_sh  = {rem_r[BW-2:0], nsh_r[BW-1]};
  assign rem_ge  = (rem_sh >= dabs_r);
  assign rem_dbl = {rem_r[BW-2:0], 1'b0};
  assign lim     = neg_r ? (BW'(1) << (OW - 1)) : ((BW'(1) << (OW - 1)) - BW'(1));
  assign over    = (quo_r > lim);
  assign qv      = over ? lim[OW-1:0] : quo_r[OW-1:0];
  assign sval    = neg_r ? -qv : qv;
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_LD : ST_IDLE;
      ST_LD:   state_nxt = ST_MUL;
      ST_MUL:  if (it_r == lscf_pkg::ITER_W'(BW - 1)) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (uop_r == lscf_pkg::UOP_W'(lscf_pkg::UOP_LAST)) ? ST_FIN : ST_LD;
      ST_FIN: begin
        if (k_r != 2'd0) begin
          state_nxt = ST_DVL;
        end else if (det_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_LD;
        end
      end
      ST_DVL:  state_nxt = ST_DIV;
      ST_DIV:  if (it_r == lscf_pkg::ITER_W'(BW - 1)) state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = (k_r == 2'd3) ? ST_EMIT : ST_LD;
      ST_EMIT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        px_r   <= in_point_x;
        py_r   <= in_point_y;
        xx_r   <= xx_w;
        yy_r   <= yy_w;
        xy_r   <= xy_w;
        last_r <= in_last_point;
      end
      ST_ACC: begin
        // hold the finished set for the solve
        snap_r  <= new_word;
        k_r     <= 2'd0;
        uop_r   <= '0;
        sat_r   <= 1'b0;
        degen_r <= 1'b0;
      end
      ST_LD: begin
        pa_r <= src_val(uop.a);
        pb_r <= src_val(uop.b);
        pp_r <= '0;
        it_r <= '0;
      end
      ST_MUL: begin
        pp_r <= pp_r + (pb_r[0] ? pa_r : '0);
        pa_r <= {pa_r[BW-2:0], 1'b0};
        pb_r <= {1'b0, pb_r[BW-1:1]};
        it_r <= it_r + lscf_pkg::ITER_W'(1);
      end
      ST_UPD: begin
        acc_r <= acc_nxt;
        case (uop.dst)
          lscf_pkg::DST_T0:   t0_r <= acc_nxt;
          lscf_pkg::DST_T1:   t1_r <= acc_nxt;
          lscf_pkg::DST_T2:   t2_r <= acc_nxt;
          default: ;
        endcase
        if (uop_r == lscf_pkg::UOP_W'(lscf_pkg::UOP_LAST)) begin
          uop_r <= '0;
          if (k_r == 2'd0) begin
            det_r <= acc_nxt;
          end else begin
            num_r <= acc_nxt;
          end
        end else begin
          uop_r <= uop_r + lscf_pkg::UOP_W'(1);
        end
      end
      ST_FIN: begin
        if (k_r == 2'd0) begin
          if (det_r == '0) begin
            degen_r <= 1'b1;
            coefa_r <= '0;
            coefb_r <= '0;
            coefc_r <= '0;
          end else begin
            k_r <= 2'd1;
          end
        end
      end
      ST_DVL: begin
        neg_r  <= num_r[BW-1] ^ det_r[BW-1];
        nsh_r  <= num_abs << FRAC_BITS;
        dabs_r <= det_abs;
        rem_r  <= '0;
        quo_r  <= '0;
        it_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_ge ? rem_sh - dabs_r : rem_sh;
        quo_r <= {quo_r[BW-2:0], rem_ge};
        nsh_r <= {nsh_r[BW-2:0], 1'b0};
        it_r  <= it_r + lscf_pkg::ITER_W'(1);
      end
      ST_RND: begin
        // round half away from zero on the magnitude
        quo_r <= quo_r + BW'(rem_dbl >= dabs_r);
      end
      ST_SAT: begin
        sat_r <= sat_r | over;
        case (k_r)
          2'd1:    coefa_r <= sval;
          2'd2:    coefb_r <= sval;
          default: coefc_r <= sval;
        endcase
        k_r <= k_r + 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_load) begin
      out_a_r     <= coefa_r;
      out_b_r     <= coefb_r;
      out_c_r     <= coefc_r;
      out_degen_r <= degen_r;
      out_sat_r   <= sat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coef_a     = out_a_r;
  assign out_coef_b     = out_b_r;
  assign out_coef_c     = out_c_r;
  assign out_degenerate = out_degen_r;
  assign out_saturated  = out_sat_r;

`ifndef SYNTH
  a_acc_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> $past(in_valid && !in_stall))
    else $error("accumulate cycle without an input transfer");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit");

  a_mul_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL && it_r != lscf_pkg::ITER_W'(BW - 1) |=> state_r == ST_MUL)
    else $error("multiply left early");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_coef_a == '0 && out_coef_b == '0 && out_coef_c == '0 && !out_saturated)
    else $error("degenerate result with nonzero fields");
`endif

endmodule
